// File: hdl/tarl_pkg.sv
package tarl_pkg;

	localparam int TIME_BITS_DEF = 32;

	localparam int CFG_W   = 16;
	localparam int INDEX_W = 3;
	localparam int COUNT_W = 32;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 72;

	// configuration register indexes
	localparam logic [INDEX_W-1:0] REG_COOLDOWN_DANGER  = 3'd0;
	localparam logic [INDEX_W-1:0] REG_COOLDOWN_WARNING = 3'd1;
	localparam logic [INDEX_W-1:0] REG_COOLDOWN_CAUTION = 3'd2;
	localparam logic [INDEX_W-1:0] REG_COOLDOWN_ADVICE  = 3'd3;
	localparam logic [INDEX_W-1:0] REG_TTC_OVERRIDE     = 3'd4;
	localparam logic [INDEX_W-1:0] REG_CAUTION_GATE     = 3'd5;

	// risk levels
	localparam logic [1:0] LVL_CLEAR   = 2'd0;
	localparam logic [1:0] LVL_CAUTION = 2'd1;
	localparam logic [1:0] LVL_WARNING = 2'd2;
	localparam logic [1:0] LVL_DANGER  = 2'd3;

	// item kinds
	localparam logic KIND_FRAME  = 1'b0;
	localparam logic KIND_ADVICE = 1'b1;

	// result slot codes
	localparam logic [2:0] SLOT_NONE   = 3'd0;
	localparam logic [2:0] SLOT_ADVICE = 3'd4;

	typedef struct packed {
		logic [CFG_W-1:0] cooldown_danger_ms;
		logic [CFG_W-1:0] cooldown_warning_ms;
		logic [CFG_W-1:0] cooldown_caution_ms;
		logic [CFG_W-1:0] cooldown_advice_ms;
		logic [CFG_W-1:0] ttc_override_ms;
		logic [CFG_W-1:0] gate_range_mm;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] now_ms;
		logic [1:0]  threat_level;
		logic        ttc_valid;
		logic [15:0] min_ttc_ms;
		logic        threat_present;
		logic [15:0] threat_distance_mm;
	} item_t;

	typedef struct packed {
		logic               fired;
		logic [2:0]         alert_slot;
		logic               use_haptic;
		logic               by_escalation;
		logic               by_ttc_override;
		logic               suppressed;
		logic [COUNT_W-1:0] spoken_count;
		logic [COUNT_W-1:0] suppressed_count;
	} result_t;

endpackage

// File: hdl/tarl_cfg_regs.sv
module tarl_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [tarl_pkg::INDEX_W-1:0]   wr_index,
	input  logic [tarl_pkg::CFG_W-1:0]     wr_data,
	output tarl_pkg::cfg_t                 cfg
);

	tarl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cooldown_danger_ms  <= 16'd2000;
			cfg_q.cooldown_warning_ms <= 16'd4000;
			cfg_q.cooldown_caution_ms <= 16'd6000;
			cfg_q.cooldown_advice_ms  <= 16'd15000;
			cfg_q.ttc_override_ms     <= 16'd1500;
			cfg_q.gate_range_mm       <= 16'd3000;
		end else if (wr_en) begin
			case (wr_index)
				tarl_pkg::REG_COOLDOWN_DANGER:  cfg_q.cooldown_danger_ms  <= wr_data;
				tarl_pkg::REG_COOLDOWN_WARNING: cfg_q.cooldown_warning_ms <= wr_data;
				tarl_pkg::REG_COOLDOWN_CAUTION: cfg_q.cooldown_caution_ms <= wr_data;
				tarl_pkg::REG_COOLDOWN_ADVICE:  cfg_q.cooldown_advice_ms  <= wr_data;
				tarl_pkg::REG_TTC_OVERRIDE:     cfg_q.ttc_override_ms     <= wr_data;
				tarl_pkg::REG_CAUTION_GATE:     cfg_q.gate_range_mm       <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/tarl_core.sv
module tarl_core #(
	parameter int TimeBits = tarl_pkg::TIME_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tarl_pkg::cfg_t      cfg,
	input  tarl_pkg::item_t     item,
	input  logic                advance,
	output tarl_pkg::result_t   result
);

	// entry 0 holds the advice slot, entries 1..3 the risk levels
	logic [TimeBits-1:0]          last_q [4];
	logic [3:0]                   ever_q;
	logic [1:0]                   prev_level_q;
	logic [tarl_pkg::COUNT_W-1:0] spoken_q;
	logic [tarl_pkg::COUNT_W-1:0] supp_q;

	logic [TimeBits-1:0] now_t;
	logic [TimeBits-1:0] elapsed [4];
	logic [TimeBits-1:0] cd_level;
	logic [3:0]          passed;
	logic                cool_ok;
	logic                esc;
	logic                ovr;
	logic                gated;
	logic                fire;
	logic                supp;
	logic                is_frame_alert;
	logic [1:0]          wr_slot;

	assign now_t = TimeBits'(item.now_ms);

	always_comb begin
		case (item.threat_level)
			tarl_pkg::LVL_DANGER:  cd_level = TimeBits'(cfg.cooldown_danger_ms);
			tarl_pkg::LVL_WARNING: cd_level = TimeBits'(cfg.cooldown_warning_ms);
			default:               cd_level = TimeBits'(cfg.cooldown_caution_ms);
		endcase
	end

	// elapsed time per slot, modulo the time width
	always_comb begin
		for (int s = 0; s < 4; s++) begin
			elapsed[s] = now_t - last_q[s];
		end
		passed[0] = !ever_q[0] || (elapsed[0] >= TimeBits'(cfg.cooldown_advice_ms));
		for (int s = 1; s < 4; s++) begin
			passed[s] = !ever_q[s] || (elapsed[s] >= cd_level);
		end
	end

	// this level and every higher level must be clear of recent alerts
	always_comb begin
		case (item.threat_level)
			tarl_pkg::LVL_CAUTION: cool_ok = passed[1] & passed[2] & passed[3];
			tarl_pkg::LVL_WARNING: cool_ok = passed[2] & passed[3];
			default:               cool_ok = passed[3];
		endcase
	end

	assign esc   = item.threat_level > prev_level_q;
	assign ovr   = item.ttc_valid && (item.min_ttc_ms < cfg.ttc_override_ms);
	assign gated = (item.threat_level == tarl_pkg::LVL_CAUTION) && item.threat_present
		&& (item.threat_distance_mm > cfg.gate_range_mm);

	always_comb begin
		fire = 1'b0;
		supp = 1'b0;
		is_frame_alert = 1'b0;
		if (item.kind == tarl_pkg::KIND_ADVICE) begin
			fire = passed[0];
			supp = !passed[0];
		end else if (item.threat_level != tarl_pkg::LVL_CLEAR) begin
			if (gated) begin
				supp = 1'b1;
			end else begin
				fire = esc || ovr || cool_ok;
				supp = !fire;
				is_frame_alert = fire;
			end
		end
	end

	assign wr_slot = (item.kind == tarl_pkg::KIND_ADVICE) ? 2'd0 : item.threat_level;

	always_comb begin
		result.fired            = fire;
		result.alert_slot       = !fire ? tarl_pkg::SLOT_NONE
			: (item.kind == tarl_pkg::KIND_ADVICE) ? tarl_pkg::SLOT_ADVICE
			: {1'b0, item.threat_level};
		result.use_haptic       = is_frame_alert
			&& (item.threat_level == tarl_pkg::LVL_CAUTION);
		result.by_escalation    = is_frame_alert && esc;
		result.by_ttc_override  = is_frame_alert && ovr;
		result.suppressed       = supp;
		result.spoken_count     = spoken_q + tarl_pkg::COUNT_W'(fire);
		result.suppressed_count = supp_q + tarl_pkg::COUNT_W'(supp);
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			last_q[wr_slot] <= now_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ever_q       <= '0;
			prev_level_q <= tarl_pkg::LVL_CLEAR;
			spoken_q     <= '0;
			supp_q       <= '0;
		end else if (advance) begin
			if (fire) begin
				ever_q[wr_slot] <= 1'b1;
			end
			if (item.kind == tarl_pkg::KIND_FRAME) begin
				prev_level_q <= item.threat_level;
			end
			spoken_q <= result.spoken_count;
			supp_q   <= result.suppressed_count;
		end
	end

endmodule

// File: hdl/tiered_alert_rate_limiter_unit.sv
// Tiered alert rate limiter. Each input transaction is a frame risk verdict
// (s_axis_tuser = 0) or an advice request (s_axis_tuser = 1) stamped with a
// millisecond time; each one yields exactly one result transaction saying
// whether an alert fired, in which slot, by which reason, and the running
// spoken and suppressed counts. Throughput is one transaction per clock while
// the result stream is not stalled; the input register loads at the accepting
// edge, the result register when the held item advances. The rate rests on the
// combinational decision path: four parallel elapsed-time compares against
// the per-slot fire stamps, whose updates land at the same edge that loads the
// result, so the next item sees them at once. The user must write cooldowns,
// the override threshold and the caution gate through the cfg port only while
// no item is in flight; the block does not enforce it, and cfg_ready is always
// high. Time stamps are kept TIME_BITS wide and compared modulo 2^TIME_BITS.
module tiered_alert_rate_limiter_unit #(
	parameter int TIME_BITS = tarl_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata from bit 0: now_ms[31:0], threat level[33:32], ttc_valid[34],
	// min_ttc_ms[50:35], threat_present[51], threat_distance_mm[67:52], zero fill
	input  logic [tarl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// tuser: kind
	input  logic                              s_axis_tuser,
	// result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata from bit 0: fired[0], alert_slot[3:1], use_haptic[4],
	// escalation reason[5], ttc override reason[6], suppressed[7],
	// spoken_count[39:8], suppressed_count[71:40]
	output logic [tarl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tarl_pkg::INDEX_W-1:0]      cfg_index,
	input  logic [tarl_pkg::CFG_W-1:0]        cfg_data
);

	tarl_pkg::cfg_t    cfg;
	tarl_pkg::item_t   item_in;
	tarl_pkg::item_t   item_s1;
	tarl_pkg::result_t result;
	tarl_pkg::result_t result_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;
	logic              in_accept;

	assign cfg_ready = 1'b1;

	tarl_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// unpack the input transaction
	always_comb begin
		item_in.kind               = s_axis_tuser;
		item_in.now_ms             = s_axis_tdata[31:0];
		item_in.threat_level       = s_axis_tdata[33:32];
		item_in.ttc_valid          = s_axis_tdata[34];
		item_in.min_ttc_ms         = s_axis_tdata[50:35];
		item_in.threat_present     = s_axis_tdata[51];
		item_in.threat_distance_mm = s_axis_tdata[67:52];
	end

	// advance the held item when the result register is free or draining
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	tarl_core #(
		.TimeBits (TIME_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (advance),
		.result  (result)
	);

	// hold the result until the consumer takes it
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {result_s2.suppressed_count,
		result_s2.spoken_count,
		result_s2.suppressed,
		result_s2.by_ttc_override,
		result_s2.by_escalation,
		result_s2.use_haptic,
		result_s2.alert_slot,
		result_s2.fired};

endmodule

// File: sim/tb_tiered_alert_rate_limiter_unit.sv
module tb_tiered_alert_rate_limiter_unit;

	// Scoreboard: keeps its own copy of the registers and the per-slot fire
	// history, and predicts one verdict per accepted item. It holds the
	// predictions until the result transactions arrive.
	class alert_verdict_board;
		tarl_pkg::cfg_t    cfg;
		logic [31:0]       fire_stamp[5];
		bit                has_fired[5];
		logic [1:0]        prior_level;
		logic [31:0]       spoken_total;
		logic [31:0]       muted_total;
		tarl_pkg::result_t pending_verdicts[$];
		int                mismatches;

		function new();
			cfg.cooldown_danger_ms  = 16'd2000;
			cfg.cooldown_warning_ms = 16'd4000;
			cfg.cooldown_caution_ms = 16'd6000;
			cfg.cooldown_advice_ms  = 16'd15000;
			cfg.ttc_override_ms     = 16'd1500;
			cfg.gate_range_mm       = 16'd3000;
			foreach (has_fired[i]) has_fired[i] = 1'b0;
			prior_level  = tarl_pkg::LVL_CLEAR;
			spoken_total = '0;
			muted_total  = '0;
			mismatches   = 0;
		endfunction

		function void write_reg(logic [tarl_pkg::INDEX_W-1:0] idx,
				logic [tarl_pkg::CFG_W-1:0] val);
			case (idx)
				tarl_pkg::REG_COOLDOWN_DANGER:  cfg.cooldown_danger_ms  = val;
				tarl_pkg::REG_COOLDOWN_WARNING: cfg.cooldown_warning_ms = val;
				tarl_pkg::REG_COOLDOWN_CAUTION: cfg.cooldown_caution_ms = val;
				tarl_pkg::REG_COOLDOWN_ADVICE:  cfg.cooldown_advice_ms  = val;
				tarl_pkg::REG_TTC_OVERRIDE:     cfg.ttc_override_ms     = val;
				tarl_pkg::REG_CAUTION_GATE:     cfg.gate_range_mm       = val;
				default: ;
			endcase
		endfunction

		// A slot that never fired counts as cooled down.
		function bit slot_cooled(int slot, logic [31:0] now, logic [15:0] cd);
			logic [31:0] elapsed;
			if (!has_fired[slot])
				return 1'b1;
			elapsed = now - fire_stamp[slot];
			return elapsed >= {16'd0, cd};
		endfunction

		function logic [15:0] level_cooldown(logic [1:0] lvl);
			case (lvl)
				tarl_pkg::LVL_DANGER:  return cfg.cooldown_danger_ms;
				tarl_pkg::LVL_WARNING: return cfg.cooldown_warning_ms;
				default:               return cfg.cooldown_caution_ms;
			endcase
		endfunction

		function void note_item(tarl_pkg::item_t it);
			tarl_pkg::result_t r;
			bit      rose;
			bit      urgent;
			bit      go;
			int      slot;
			r = '0;
			if (it.kind == tarl_pkg::KIND_ADVICE) begin
				if (slot_cooled(int'(tarl_pkg::SLOT_ADVICE), it.now_ms,
						cfg.cooldown_advice_ms)) begin
					fire_stamp[tarl_pkg::SLOT_ADVICE] = it.now_ms;
					has_fired[tarl_pkg::SLOT_ADVICE]  = 1'b1;
					spoken_total++;
					r.fired      = 1'b1;
					r.alert_slot = tarl_pkg::SLOT_ADVICE;
				end else begin
					muted_total++;
					r.suppressed = 1'b1;
				end
			end else if (it.threat_level != tarl_pkg::LVL_CLEAR) begin
				rose   = it.threat_level > prior_level;
				urgent = it.ttc_valid && (it.min_ttc_ms < cfg.ttc_override_ms);
				if (it.threat_level == tarl_pkg::LVL_CAUTION && it.threat_present &&
						it.threat_distance_mm > cfg.gate_range_mm) begin
					muted_total++;
					r.suppressed = 1'b1;
				end else begin
					go = rose || urgent;
					if (!go) begin
						// every slot at this level and above must be cooled
						go = 1'b1;
						for (slot = int'(it.threat_level);
								slot <= int'(tarl_pkg::LVL_DANGER); slot++)
							if (!slot_cooled(slot, it.now_ms,
									level_cooldown(it.threat_level)))
								go = 1'b0;
					end
					if (go) begin
						fire_stamp[it.threat_level] = it.now_ms;
						has_fired[it.threat_level]  = 1'b1;
						spoken_total++;
						r.fired           = 1'b1;
						r.alert_slot      = {1'b0, it.threat_level};
						r.use_haptic      = (it.threat_level == tarl_pkg::LVL_CAUTION);
						r.by_escalation   = rose;
						r.by_ttc_override = urgent;
					end else begin
						muted_total++;
						r.suppressed = 1'b1;
					end
				end
				prior_level = it.threat_level;
			end else begin
				prior_level = tarl_pkg::LVL_CLEAR;
			end
			r.spoken_count     = spoken_total;
			r.suppressed_count = muted_total;
			pending_verdicts.push_back(r);
		endfunction

		function void match_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_verdict(logic [tarl_pkg::OUT_TDATA_W-1:0] d);
			tarl_pkg::result_t want;
			if (pending_verdicts.size() == 0) begin
				$error("result transaction with no item waiting");
				mismatches++;
				return;
			end
			want = pending_verdicts.pop_front();
			match_field("fired", 32'(want.fired), 32'(d[0]));
			match_field("alert_slot", 32'(want.alert_slot), 32'(d[3:1]));
			match_field("use_haptic", 32'(want.use_haptic), 32'(d[4]));
			match_field("escalation", 32'(want.by_escalation), 32'(d[5]));
			match_field("ttc_override", 32'(want.by_ttc_override), 32'(d[6]));
			match_field("suppressed", 32'(want.suppressed), 32'(d[7]));
			match_field("spoken_count", want.spoken_count, d[39:8]);
			match_field("suppressed_count", want.suppressed_count, d[71:40]);
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	// tdata from bit 0: now_ms, threat level, ttc_valid, min_ttc_ms,
	// threat_present, threat_distance_mm, zero fill
	logic [tarl_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	// tuser: kind
	logic                             s_axis_tuser;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	// tdata from bit 0: fired, alert_slot, use_haptic, escalation reason,
	// ttc override reason, suppressed, spoken_count, suppressed_count
	logic [tarl_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [tarl_pkg::INDEX_W-1:0]     cfg_index;
	logic [tarl_pkg::CFG_W-1:0]       cfg_data;

	alert_verdict_board board = new();

	// Knobs shared between the main sequence and the receiver.
	bit          sender_idles;
	bit          sink_idles;
	int          hold_cycles;
	// running time base for random frames
	logic [31:0] clock_ms;

	tiered_alert_rate_limiter_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Sample both streams at the rising edge. Check the result before noting
	// the input so a stray result can never pair with an item of this edge.
	always @(posedge clk) begin
		tarl_pkg::item_t seen;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				board.check_verdict(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready) begin
				seen.kind               = s_axis_tuser;
				seen.now_ms             = s_axis_tdata[31:0];
				seen.threat_level       = s_axis_tdata[33:32];
				seen.ttc_valid          = s_axis_tdata[34];
				seen.min_ttc_ms         = s_axis_tdata[50:35];
				seen.threat_present     = s_axis_tdata[51];
				seen.threat_distance_mm = s_axis_tdata[67:52];
				board.note_item(seen);
			end
		end
	end

	// Receiver: honor a long hold when asked, else stall in short random
	// bursts while idling is on, else stay ready.
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
				m_axis_tready <= 1'b1;
			end else if (sink_idles && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Offer one item, possibly after a short gap, and hold it until accepted.
	task automatic send_item(tarl_pkg::item_t it);
		int gap;
		gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.kind;
		s_axis_tdata  <= {4'd0, it.threat_distance_mm, it.threat_present, it.min_ttc_ms,
			it.ttc_valid, it.threat_level, it.now_ms};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stop offering and wait for every predicted verdict to come back.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (board.pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(logic [tarl_pkg::INDEX_W-1:0] idx,
			logic [tarl_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic tarl_pkg::item_t frame_item(logic [31:0] now, logic [1:0] lvl,
			logic tv, logic [15:0] ttc, logic thr, logic [15:0] range_mm);
		tarl_pkg::item_t it;
		it.kind               = tarl_pkg::KIND_FRAME;
		it.now_ms             = now;
		it.threat_level       = lvl;
		it.ttc_valid          = tv;
		it.min_ttc_ms         = ttc;
		it.threat_present     = thr;
		it.threat_distance_mm = range_mm;
		return it;
	endfunction

	function automatic tarl_pkg::item_t as_advice(tarl_pkg::item_t it);
		it.kind = tarl_pkg::KIND_ADVICE;
		return it;
	endfunction

	// Random item on a mostly advancing time base; steps cluster around the
	// cooldowns, thresholds land on and beside the registers, with the odd
	// jump of the clock anywhere in its range.
	function automatic tarl_pkg::item_t random_item();
		tarl_pkg::item_t it;
		logic [15:0]     thr;
		logic [15:0]     gate;
		int              pick;
		thr  = board.cfg.ttc_override_ms;
		gate = board.cfg.gate_range_mm;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			clock_ms = $urandom;
		else if (pick <= 2)
			clock_ms += $urandom_range(0, 70000);
		else if (pick <= 12)
			clock_ms += $urandom_range(1, 3000);
		it.kind           = ($urandom_range(0, 5) == 0) ? tarl_pkg::KIND_ADVICE
			: tarl_pkg::KIND_FRAME;
		it.now_ms         = clock_ms;
		it.threat_level   = 2'($urandom_range(0, 3));
		it.ttc_valid      = 1'($urandom_range(0, 1));
		it.threat_present = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 3))
			0: it.min_ttc_ms = 16'($urandom);
			1: it.min_ttc_ms = thr - 16'd1;
			2: it.min_ttc_ms = thr;
			default: it.min_ttc_ms = 16'($urandom_range(0, 32'(thr)));
		endcase
		case ($urandom_range(0, 3))
			0: it.threat_distance_mm = 16'($urandom);
			1: it.threat_distance_mm = gate;
			2: it.threat_distance_mm = gate + 16'd1;
			default: it.threat_distance_mm = 16'($urandom_range(0, 32'(gate)));
		endcase
		return it;
	endfunction

	// Walk the reset settings through every decision path:
	// danger 2000, warning 4000, caution 6000, advice 15000, override 1500, gate 3000.
	task automatic directed_items();
		// clear frame only records the level
		send_item(frame_item(32'd1000, tarl_pkg::LVL_CLEAR, 1'b0, 16'd0, 1'b0, 16'd0));
		// caution with a threat beyond the gate, farthest distance
		send_item(frame_item(32'd1100, tarl_pkg::LVL_CAUTION, 1'b0, 16'hFFFF, 1'b1,
			16'hFFFF));
		// threat exactly on the gate passes; ttc just under the threshold
		send_item(frame_item(32'd1200, tarl_pkg::LVL_CAUTION, 1'b1, 16'd1499, 1'b1,
			16'd3000));
		// ttc on the threshold, no threat: caution still cooling down
		send_item(frame_item(32'd1300, tarl_pkg::LVL_CAUTION, 1'b1, 16'd1500, 1'b0,
			16'hFFFF));
		// escalations
		send_item(frame_item(32'd1400, tarl_pkg::LVL_WARNING, 1'b0, 16'd0, 1'b0, 16'd0));
		send_item(frame_item(32'd1500, tarl_pkg::LVL_DANGER, 1'b0, 16'd0, 1'b1, 16'd0));
		// repeat inside the cooldown, then ttc override at zero ttc
		send_item(frame_item(32'd1600, tarl_pkg::LVL_DANGER, 1'b0, 16'd0, 1'b0, 16'd0));
		send_item(frame_item(32'd1700, tarl_pkg::LVL_DANGER, 1'b1, 16'd0, 1'b0, 16'd0));
		// one short of the cooldown, then exactly on it
		send_item(frame_item(32'd3699, tarl_pkg::LVL_DANGER, 1'b0, 16'd0, 1'b0, 16'd0));
		send_item(frame_item(32'd3700, tarl_pkg::LVL_DANGER, 1'b0, 16'd0, 1'b0, 16'd0));
		// warning held back by its own slot, then by the danger slot above it
		send_item(frame_item(32'd3800, tarl_pkg::LVL_WARNING, 1'b0, 16'd0, 1'b0, 16'd0));
		send_item(frame_item(32'd5500, tarl_pkg::LVL_WARNING, 1'b0, 16'd0, 1'b0, 16'd0));
		send_item(frame_item(32'd7700, tarl_pkg::LVL_WARNING, 1'b0, 16'd0, 1'b0, 16'd0));
		// drop to clear, then a caution fires by escalation with haptics
		send_item(frame_item(32'd7800, tarl_pkg::LVL_CLEAR, 1'b0, 16'd0, 1'b0, 16'd0));
		send_item(frame_item(32'd7900, tarl_pkg::LVL_CAUTION, 1'b0, 16'd0, 1'b0, 16'd0));
		// advice: first ever, one short of its cooldown, exactly on it
		send_item(as_advice(frame_item(32'd8000, tarl_pkg::LVL_CLEAR, 1'b0, 16'd0, 1'b0,
			16'd0)));
		send_item(as_advice(frame_item(32'd22999, tarl_pkg::LVL_DANGER, 1'b1, 16'd0, 1'b1,
			16'd0)));
		send_item(as_advice(frame_item(32'd23000, tarl_pkg::LVL_CLEAR, 1'b0, 16'd0, 1'b0,
			16'd0)));
		// elapsed time across the wrap of the millisecond counter
		send_item(frame_item(32'hFFFF_FF00, tarl_pkg::LVL_DANGER, 1'b0, 16'd0, 1'b0,
			16'd0));
		send_item(frame_item(32'h0000_0500, tarl_pkg::LVL_DANGER, 1'b0, 16'd0, 1'b0,
			16'd0));
		send_item(frame_item(32'h0000_0800, tarl_pkg::LVL_DANGER, 1'b0, 16'd0, 1'b0,
			16'd0));
		// every field at its top value, as advice and as a clear frame
		send_item(as_advice(frame_item(32'hFFFF_FFFF, tarl_pkg::LVL_DANGER, 1'b1, 16'hFFFF,
			1'b1, 16'hFFFF)));
		send_item(frame_item(32'hFFFF_FFFF, tarl_pkg::LVL_CLEAR, 1'b1, 16'hFFFF, 1'b1,
			16'hFFFF));
	endtask

	// Quiesce, load all six registers, then stream random items. At hold_at,
	// ask the receiver for a long hold while the items keep coming.
	task automatic run_phase(logic [tarl_pkg::CFG_W-1:0] cd_danger,
			logic [tarl_pkg::CFG_W-1:0] cd_warning,
			logic [tarl_pkg::CFG_W-1:0] cd_caution, logic [tarl_pkg::CFG_W-1:0] cd_advice,
			logic [tarl_pkg::CFG_W-1:0] ttc_thr, logic [tarl_pkg::CFG_W-1:0] gate,
			int count, bit idles, int hold_at);
		drain();
		write_cfg(tarl_pkg::REG_COOLDOWN_DANGER, cd_danger);
		write_cfg(tarl_pkg::REG_COOLDOWN_WARNING, cd_warning);
		write_cfg(tarl_pkg::REG_COOLDOWN_CAUTION, cd_caution);
		write_cfg(tarl_pkg::REG_COOLDOWN_ADVICE, cd_advice);
		write_cfg(tarl_pkg::REG_TTC_OVERRIDE, ttc_thr);
		write_cfg(tarl_pkg::REG_CAUTION_GATE, gate);
		sender_idles = idles;
		sink_idles   = idles;
		for (int n = 0; n < count; n++) begin
			if (n == hold_at)
				hold_cycles = 300;
			send_item(random_item());
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = tarl_pkg::KIND_FRAME;
		cfg_valid     = 1'b0;
		cfg_index     = tarl_pkg::REG_COOLDOWN_DANGER;
		cfg_data      = '0;
		sender_idles  = 1'b1;
		sink_idles    = 1'b1;
		hold_cycles   = 0;
		clock_ms      = 32'h0001_0000;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_items();
		// reset values again, with the long receiver hold
		run_phase(16'd2000, 16'd4000, 16'd6000, 16'd15000, 16'd1500, 16'd3000, 250, 1'b1, 60);
		// all zero: no cooldown, no override, any distant threat gates caution
		run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 250, 1'b1, -1);
		// all at the top
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 250, 1'b1, -1);
		run_phase(16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
			16'($urandom_range(0, 8000)), 16'($urandom_range(0, 20000)),
			16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
			250, 1'b1, -1);
		// last stretch at full rate, time base just short of the wrap
		clock_ms = 32'hFFFE_0000;
		run_phase(16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
			16'($urandom_range(0, 8000)), 16'($urandom_range(0, 20000)),
			16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
			250, 1'b0, -1);
		drain();

		if (board.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog for a stuck handshake.
	initial begin
		#3000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
